// ----- src/trf_pkg.sv -----
// trf_pkg: shared types and helpers for the trend reversal finder.
// No dependencies; used by the channel interfaces and all modules.

package trf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 9;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [INDEX_W-1:0]         index_t;

  // Trend direction between two samples; 2'b10 has no meaning.
  typedef enum logic [1:0] {
    DIR_FLAT = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_t;

  // Trend state carried from one judged sample to the next.
  typedef struct packed {
    sample_t value;
    logic    missing;
    dir_t    direction;
  } prior_t;

  // Direction from b to a.
  function automatic dir_t dir_of(sample_t a, sample_t b);
    dir_t d;
    if (a < b) begin
      d = DIR_DOWN;
    end else if (a > b) begin
      d = DIR_UP;
    end else begin
      d = DIR_FLAT;
    end
    return d;
  endfunction

endpackage

// ----- src/trf_if.sv -----
// Valid/ready channels of the trend reversal finder: samples in, turns out.
// Depends on trf_pkg.

interface trf_sample_if;
  logic              valid;
  logic              ready;
  trf_pkg::sample_t  sample_value;
  logic              sample_missing;
  logic              frame_last;

  modport source (output valid, sample_value, sample_missing, frame_last, input ready);
  modport sink   (input valid, sample_value, sample_missing, frame_last, output ready);
endinterface

interface trf_turn_if;
  logic             valid;
  logic             ready;
  trf_pkg::index_t  turn_index;
  logic             turn_found;

  modport source (output valid, turn_index, turn_found, input ready);
  modport sink   (input valid, turn_index, turn_found, output ready);
endinterface

// ----- src/trend_reversal_finder.sv -----
// trend_reversal_finder: one-sample-per-cycle turning point search over framed series.
// Depends on trf_pkg, trf_if (trf_sample_if, trf_turn_if) and trf_judge.
//
// Usage:
//   samples: valid/ready stream of sample_value, sample_missing, frame_last.
//   turns:   one item per frame, sent after the frame_last sample; turn_index
//            is the reversal position minus one (1 when none), turn_found flags
//            whether a reversal was seen.
//   cfg_write/cfg_data write pick_last (0 keeps first reversal, 1 keeps last).
// Each sample is held one step so it can be judged against the next one.
// Throughput: one sample per cycle while no frame_last sample waits for the result
// register; the input register and the compare logic behind it advance whenever
// that holds. Result path: input register, then result register.
// Stall: if the turns receiver holds ready low, the result waits in the
// output register; only a following frame_last sample blocks, earlier samples
// of the next frame still flow.
// Reset (rst, synchronous) clears frame state, pick_last and both valids.
// Frames longer than MAX_SERIES still run; late positions never count.

module trend_reversal_finder #(
  parameter int MAX_SERIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  trf_sample_if.sink         samples,
  trf_turn_if.source         turns
);

  localparam int CNT_W = $clog2(MAX_SERIES + 2);

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t POS_MIN  = CNT_W'(2);
  localparam cnt_t POS_LIM  = CNT_W'(MAX_SERIES);
  localparam cnt_t CNT_SAT  = CNT_W'(MAX_SERIES + 1);

  logic pick_last;

  // input register
  logic             s1_valid;
  trf_pkg::sample_t s1_value;
  logic             s1_missing;
  logic             s1_last;

  // frame state
  trf_pkg::prior_t  prior;
  trf_pkg::sample_t held_value;
  logic             held_missing;
  logic             held_valid;
  cnt_t             count;
  cnt_t             best;
  logic             done;
  logic             seen;

  // result register
  logic             res_valid;
  trf_pkg::index_t  res_index;
  logic             res_found;

  logic             adv;
  trf_pkg::dir_t    ahead_dir;
  cnt_t             pos_h;
  logic             pos_ok_h;
  logic             pos_ok_c;
  trf_pkg::prior_t  prior_j1;
  logic             hit_h;
  logic             hit1;
  logic             hit2;
  trf_pkg::prior_t  prior1;
  cnt_t             best1;
  logic             seen1;
  logic             done1;
  cnt_t             best2;
  logic             seen2;
  cnt_t             idx_wide;

  // only a frame_last item needs room in the result register
  assign adv = s1_valid && (!s1_last || !res_valid || turns.ready);
  assign samples.ready = !s1_valid || adv;

  assign turns.valid      = res_valid;
  assign turns.turn_index = res_index;
  assign turns.turn_found = res_found;

  // judge the held sample with the incoming one as look-ahead
  always_comb begin
    if (s1_missing) begin
      ahead_dir = trf_pkg::DIR_UP;
    end else if (held_missing) begin
      ahead_dir = trf_pkg::DIR_FLAT;
    end else begin
      ahead_dir = trf_pkg::dir_of(s1_value, held_value);
    end
  end

  assign pos_h    = count - 1'b1;
  assign pos_ok_h = (pos_h >= POS_MIN) && (pos_h < POS_LIM);
  assign pos_ok_c = (count >= POS_MIN) && (count < POS_LIM);

  trf_judge u_judge_held (
    .prior      (prior),
    .done       (done),
    .value      (held_value),
    .missing    (held_missing),
    .pos_ok     (pos_ok_h),
    .ahead_same (1'b0),
    .ahead_dir  (ahead_dir),
    .prior_next (prior_j1),
    .hit        (hit_h)
  );

  assign hit1 = held_valid && hit_h;

  always_comb begin
    prior1 = held_valid ? prior_j1 : prior;
    best1  = hit1 ? pos_h : best;
    seen1  = seen | hit1;
    done1  = done | (hit1 & ~pick_last);
    // first sample of a frame compares with itself
    if (count == '0) begin
      prior1.value   = s1_value;
      prior1.missing = s1_missing;
    end
  end

  // last sample of a frame: judged at once, look-ahead equals its own direction
  trf_judge u_judge_last (
    .prior      (prior1),
    .done       (done1),
    .value      (s1_value),
    .missing    (s1_missing),
    .pos_ok     (pos_ok_c),
    .ahead_same (1'b1),
    .ahead_dir  (trf_pkg::DIR_FLAT),
    .prior_next (),
    .hit        (hit2)
  );

  assign best2    = hit2 ? count : best1;
  assign seen2    = seen1 | hit2;
  assign idx_wide = best2 - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_last <= 1'b0;
    end else if (cfg_write) begin
      pick_last <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_value   <= samples.sample_value;
      s1_missing <= samples.sample_missing;
      s1_last    <= samples.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && s1_last)) begin
      prior        <= '{value: '0, missing: 1'b0, direction: trf_pkg::DIR_FLAT};
      held_value   <= '0;
      held_missing <= 1'b0;
      held_valid   <= 1'b0;
      count        <= '0;
      best         <= POS_MIN;
      done         <= 1'b0;
      seen         <= 1'b0;
    end else if (adv) begin
      prior        <= prior1;
      held_value   <= s1_value;
      held_missing <= s1_missing;
      held_valid   <= 1'b1;
      if (count < CNT_SAT) begin
        count <= count + 1'b1;
      end
      best <= best1;
      done <= done1;
      seen <= seen1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && s1_last) begin
      res_valid <= 1'b1;
    end else if (turns.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      res_index <= trf_pkg::INDEX_W'(idx_wide);
      res_found <= seen2;
    end
  end

`ifndef ASSERT_OFF
  a_rise_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(adv && s1_last))
    else $error("result appeared without a frame_last item");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_last) |=> (count == '0) && !held_valid && !seen && !done)
    else $error("frame state not cleared after frame end");

  a_none_index: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_index == trf_pkg::INDEX_W'(1)))
    else $error("no reversal but index is not one");

  a_held_count: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (count != '0))
    else $error("sample held with zero position count");

  a_done_seen: assert property (@(posedge clk) disable iff (rst)
    done |-> seen)
    else $error("search stopped without a reversal");
`endif

endmodule

// ----- src/trf_judge.sv -----
// trf_judge: decides whether one sample is a trend reversal and updates
// the carried trend state. Purely combinational. Depends on trf_pkg.

module trf_judge (
  input  trf_pkg::prior_t  prior,
  input  logic             done,
  input  trf_pkg::sample_t value,
  input  logic             missing,
  input  logic             pos_ok,
  input  logic             ahead_same,
  input  trf_pkg::dir_t    ahead_dir,
  output trf_pkg::prior_t  prior_next,
  output logic             hit
);

  trf_pkg::dir_t dir;
  trf_pkg::dir_t fut;

  // a missing previous sample counts as above any value
  assign dir = prior.missing ? trf_pkg::DIR_DOWN : trf_pkg::dir_of(value, prior.value);
  assign fut = ahead_same ? dir : ahead_dir;

  assign hit = !done && !missing && pos_ok && (dir != trf_pkg::DIR_FLAT) &&
               (dir != prior.direction) && (fut == dir);

  always_comb begin
    prior_next = prior;
    if (!done) begin
      prior_next.value   = value;
      prior_next.missing = missing;
      if (!missing) begin
        prior_next.direction = dir;
      end
    end
  end

endmodule
